FILE: hw/rtl/rba_pkg.sv
package rba_pkg;

    // Sizing of the offset queue and the data paths.
    localparam int MAX_BLOCKS = 64;
    localparam int PTR_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_BITS  = 32;
    localparam int SIZE_W     = 32;
    localparam int ALIGN_W    = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2 = 4'd1;

    // Configuration reset values.
    localparam logic [SIZE_W-1:0]  HEAP_RESET  = 32'd65536;
    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 5'd8;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } rba_op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } rba_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } rba_state_t;

    // Request word.
    typedef struct packed {
        rba_op_t             opcode;
        logic [SIZE_W-1:0]   request_size;
    } rba_req_t;

    // Result word.
    typedef struct packed {
        rba_status_t          status;
        logic [ADDR_BITS-1:0] block_offset;
        logic [SIZE_W-1:0]    block_size;
    } rba_rsp_t;

    // Write port of the offset queue memory.
    typedef struct packed {
        logic                 en;
        logic [PTR_W-1:0]     addr;
        logic [ADDR_BITS-1:0] data;
    } rba_wr_t;

endpackage

FILE: hw/rtl/ring_buffer_allocator_unit.sv
// Ring allocator over one heap, with a queue of up to 64 live block offsets.
//
// Request channel: drive req (opcode, request_size) with start high; the word
// is taken at a rising edge where start is high and busy is low. An allocate
// rounds the size up to a multiple of 2^align_log2 and places it at the running
// free offset, or at offset zero when the tail is short and the space before
// the oldest block fits. A release drops the oldest block and returns its
// offset. Result channel: done pulses for one cycle with the result word
// (status, block_offset, block_size). The receiver cannot hold it off.
// Sequence: the idle state takes the word, the read state reads the oldest
// offset out of the queue memory, and the exec state places or releases and
// writes the memory back; done and the result word are registered from the
// exec state. No new word is accepted until the unit is idle again.
// Configuration: heap_bytes (index 0) and align_log2 (index 1) are written on
// cfg_valid; cfg_ready is always high. Write only while the unit is idle.
// Reset: the queue is emptied, the free offset goes to zero, heap_bytes to
// 65536 and align_log2 to 8. No clearing pass is needed.
module ring_buffer_allocator_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  rba_pkg::rba_req_t                     req,
    output logic                                  busy,
    output logic                                  done,
    output rba_pkg::rba_rsp_t                     result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rba_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rba_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic [rba_pkg::SIZE_W-1:0]    heap_reg;
    logic [rba_pkg::ALIGN_W-1:0]   align_reg;
    rba_pkg::rba_wr_t              mem_wr;
    logic                          mem_rd_en;
    logic [rba_pkg::PTR_W-1:0]     mem_rd_addr;
    logic [rba_pkg::ADDR_BITS-1:0] mem_rd_data;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg  <= rba_pkg::HEAP_RESET;
            align_reg <= rba_pkg::ALIGN_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == rba_pkg::CFG_HEAP_BYTES)
            begin
                heap_reg <= cfg_data[rba_pkg::SIZE_W-1:0];
            end
            else if (cfg_index == rba_pkg::CFG_ALIGN_LOG2)
            begin
                align_reg <= cfg_data[rba_pkg::ALIGN_W-1:0];
            end
        end
    end

    assign cfg_ready = 1'b1;

    rba_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .heap_bytes  (heap_reg),
        .align_log2  (align_reg),
        .start       (start),
        .req         (req),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .mem_wr      (mem_wr),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    rba_fifo_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

FILE: hw/rtl/rba_fifo_mem.sv
module rba_fifo_mem (
    input  logic                                 clk,
    input  rba_pkg::rba_wr_t                     wr,
    input  logic                                 rd_en,
    input  logic [rba_pkg::PTR_W-1:0]            rd_addr,
    output logic [rba_pkg::ADDR_BITS-1:0]        rd_data
);

    logic [rba_pkg::ADDR_BITS-1:0] mem [rba_pkg::MAX_BLOCKS];
    logic [rba_pkg::ADDR_BITS-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/rba_core.sv
module rba_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [rba_pkg::SIZE_W-1:0]           heap_bytes,
    input  logic [rba_pkg::ALIGN_W-1:0]          align_log2,
    input  logic                                 start,
    input  rba_pkg::rba_req_t                    req,
    output logic                                 busy,
    output logic                                 done,
    output rba_pkg::rba_rsp_t                    result,
    output rba_pkg::rba_wr_t                     mem_wr,
    output logic                                 mem_rd_en,
    output logic [rba_pkg::PTR_W-1:0]            mem_rd_addr,
    input  logic [rba_pkg::ADDR_BITS-1:0]        mem_rd_data
);

    localparam int SW = rba_pkg::SIZE_W;
    localparam int AW = rba_pkg::ADDR_BITS;
    localparam int PW = rba_pkg::PTR_W;
    localparam int CW = rba_pkg::CNT_W;

    rba_pkg::rba_state_t state_reg, state_next;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] live_reg, live_next;
    logic [AW-1:0] free_reg, free_next;
    logic          done_reg, done_next;

    rba_pkg::rba_req_t req_reg;
    logic [SW-1:0]     asize_reg, asize_next;
    logic              large_reg, large_next;
    rba_pkg::rba_rsp_t result_reg, result_next;

    logic [SW:0]   align_mask;
    logic [SW:0]   size_sum;
    logic [SW:0]   size_aligned;
    logic [AW-1:0] oldest;
    logic [AW-1:0] gap;
    logic [SW-1:0] tail_room;
    logic [AW-1:0] place;
    logic          fits;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] i);
        return (i == PW'(rba_pkg::MAX_BLOCKS - 1)) ? '0 : i + 1'b1;
    endfunction

    // Sequencer: read the oldest entry, then place or release.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rba_pkg::S_IDLE: if (start) state_next = rba_pkg::S_READ;
            rba_pkg::S_READ: state_next = rba_pkg::S_EXEC;
            rba_pkg::S_EXEC: state_next = rba_pkg::S_IDLE;
            default:         state_next = rba_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = 1'b1;
        mem_rd_en = 1'b0;
        unique case (state_reg)
            rba_pkg::S_IDLE: busy = 1'b0;
            rba_pkg::S_READ: mem_rd_en = 1'b1;
            rba_pkg::S_EXEC: busy = 1'b1;
            default:         busy = 1'b1;
        endcase
    end

    assign mem_rd_addr = head_reg;

    // Size rounding during the memory read cycle.
    always_comb
    begin
        align_mask   = ~({(SW + 1){1'b1}} << align_log2);
        size_sum     = {1'b0, req_reg.request_size} + align_mask;
        size_aligned = size_sum & ~align_mask;
        large_next   = size_aligned > {1'b0, heap_bytes};
        asize_next   = size_aligned[SW-1:0];
    end

    // Placement and release once the oldest offset is back from memory.
    always_comb
    begin
        oldest    = mem_rd_data;
        gap       = oldest - free_reg;
        tail_room = (free_reg > heap_bytes) ? '0 : heap_bytes - free_reg;
        place     = free_reg;
        fits      = 1'b0;

        head_next   = head_reg;
        tail_next   = tail_reg;
        live_next   = live_reg;
        free_next   = free_reg;
        done_next   = 1'b0;
        mem_wr      = '0;
        result_next = '0;
        result_next.status = rba_pkg::ST_OK;

        if (state_reg == rba_pkg::S_EXEC)
        begin
            done_next = 1'b1;
            if (req_reg.opcode == rba_pkg::OP_ALLOC)
            begin
                if (large_reg)
                begin
                    result_next.status = rba_pkg::ST_TOO_LARGE;
                end
                else if (live_reg >= CW'(rba_pkg::MAX_BLOCKS))
                begin
                    result_next.status = rba_pkg::ST_FULL;
                end
                else
                begin
                    fits = 1'b1;
                    if (live_reg != '0)
                    begin
                        if (oldest >= free_reg)
                        begin
                            fits = gap >= asize_reg;
                        end
                        else if (tail_room < asize_reg)
                        begin
                            if (oldest >= asize_reg)
                            begin
                                place = '0;
                            end
                            else
                            begin
                                fits = 1'b0;
                            end
                        end
                    end
                    if (fits)
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = tail_reg;
                        mem_wr.data = place;
                        tail_next   = ring_next(tail_reg);
                        live_next   = live_reg + 1'b1;
                        free_next   = place + asize_reg;
                        result_next.block_offset = place;
                        result_next.block_size   = asize_reg;
                    end
                    else
                    begin
                        result_next.status = rba_pkg::ST_NO_SPACE;
                    end
                end
            end
            else
            begin
                if (live_reg == '0)
                begin
                    result_next.status = rba_pkg::ST_EMPTY;
                end
                else
                begin
                    result_next.block_offset = oldest;
                    head_next = ring_next(head_reg);
                    live_next = live_reg - 1'b1;
                    if (live_reg == CW'(1))
                    begin
                        free_next = '0;
                    end
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rba_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            live_reg  <= '0;
            free_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            live_reg  <= live_next;
            free_reg  <= free_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == rba_pkg::S_IDLE && start)
        begin
            req_reg <= req;
        end
        if (state_reg == rba_pkg::S_READ)
        begin
            asize_reg <= asize_next;
            large_reg <= large_next;
        end
        if (state_reg == rba_pkg::S_EXEC)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hw/rtl/rba_checker.sv
module rba_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              done,
    input  rba_pkg::rba_rsp_t result
);

    // Every accepted word gives its result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result did not follow an accepted word");

    // The unit goes busy right after it accepts a word.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // A result is only seen after a busy cycle, and never twice in a row.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !$past(done)))
        else $error("result word without work in progress");

    // A failed request grants nothing.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != rba_pkg::ST_OK) |->
        (result.block_offset == '0 && result.block_size == '0))
        else $error("failed request carries a block");

endmodule

bind ring_buffer_allocator_unit rba_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: sim/tb.sv
module tb;

    // Index that maps to no register; a write to it must change nothing.
    localparam logic [rba_pkg::CFG_IDX_W-1:0] CFG_SPARE = 4'd15;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           start     = 1'b0;
    rba_pkg::rba_req_t              req       = '0;
    logic                           busy;
    logic                           done;
    rba_pkg::rba_rsp_t              result;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [rba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rba_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    ring_buffer_allocator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Mirror of the allocator: configuration, offset ring and free pointer.
    logic [31:0]     heap_cfg  = rba_pkg::HEAP_RESET;
    logic [4:0]      align_cfg = rba_pkg::ALIGN_RESET;
    logic [31:0]     ring_offsets [rba_pkg::MAX_BLOCKS];
    int              ring_head   = 0;
    int              ring_tail   = 0;
    int              live_blocks = 0;
    logic [31:0]     free_ptr    = '0;

    // Expected results in order, plus bookkeeping for the summary.
    rba_pkg::rba_rsp_t pending_results [$];
    bit              start_on      = 1'b0;
    bit              no_idle       = 1'b0;
    int              fail_count    = 0;
    int              words_sent    = 0;
    int              results_seen  = 0;
    int              config_count  = 0;
    int              wrap_count    = 0;
    int              status_seen [5];

    // Work out the result of one request word and advance the mirrored state.
    function automatic rba_pkg::rba_rsp_t allocate_or_release(rba_pkg::rba_req_t w);
        rba_pkg::rba_rsp_t r;
        logic [63:0] round_mask;
        logic [63:0] rounded;
        logic [63:0] oldest;
        logic [63:0] tail_room;
        logic [63:0] place;
        logic [63:0] heap_wide;
        bit          fits;
        r.status       = rba_pkg::ST_OK;
        r.block_offset = '0;
        r.block_size   = '0;
        heap_wide      = {32'd0, heap_cfg};
        if (w.opcode == rba_pkg::OP_ALLOC)
        begin
            round_mask = (64'd1 << align_cfg) - 64'd1;
            rounded    = ({32'd0, w.request_size} + round_mask) & ~round_mask;
            place      = {32'd0, free_ptr};
            fits       = 1'b1;
            if (rounded > heap_wide)
            begin
                r.status = rba_pkg::ST_TOO_LARGE;
                fits     = 1'b0;
            end
            else if (live_blocks >= rba_pkg::MAX_BLOCKS)
            begin
                r.status = rba_pkg::ST_FULL;
                fits     = 1'b0;
            end
            else if (live_blocks > 0)
            begin
                oldest = {32'd0, ring_offsets[ring_head]};
                if (oldest >= place)
                begin
                    fits = (oldest - place) >= rounded;
                end
                else
                begin
                    // A heap shrunk below the free pointer leaves no tail room.
                    tail_room = (place > heap_wide) ? 64'd0 : heap_wide - place;
                    if (tail_room < rounded)
                    begin
                        if (oldest >= rounded)
                            place = 64'd0;
                        else
                            fits = 1'b0;
                    end
                end
                if (!fits)
                    r.status = rba_pkg::ST_NO_SPACE;
            end
            if (fits)
            begin
                if (place == 64'd0 && free_ptr != 32'd0)
                    wrap_count++;
                ring_offsets[ring_tail] = place[31:0];
                ring_tail      = (ring_tail + 1) % rba_pkg::MAX_BLOCKS;
                live_blocks++;
                free_ptr       = place[31:0] + rounded[31:0];
                r.block_offset = place[31:0];
                r.block_size   = rounded[31:0];
            end
        end
        else
        begin
            if (live_blocks == 0)
            begin
                r.status = rba_pkg::ST_EMPTY;
            end
            else
            begin
                r.block_offset = ring_offsets[ring_head];
                ring_head      = (ring_head + 1) % rba_pkg::MAX_BLOCKS;
                live_blocks--;
                if (live_blocks == 0)
                    free_ptr = '0;
            end
        end
        status_seen[int'(r.status)]++;
        return r;
    endfunction

    // Drop start, unless it is already low.
    task automatic lower_start();
        if (start_on)
        begin
            start    <= 1'b0;
            start_on = 1'b0;
        end
    endtask

    // Present one request word after a random gap and wait until it is taken.
    task automatic send_word(rba_pkg::rba_req_t w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            lower_start();
            repeat (gap) @(posedge clk);
        end
        if (!start_on)
        begin
            start    <= 1'b1;
            start_on = 1'b1;
        end
        req <= w;
        do @(posedge clk); while (busy);
        pending_results.push_back(allocate_or_release(w));
        words_sent++;
    endtask

    task automatic request_alloc(logic [31:0] size);
        rba_pkg::rba_req_t w;
        w.opcode       = rba_pkg::OP_ALLOC;
        w.request_size = size;
        send_word(w);
    endtask

    // The size field is ignored on release, so it carries random bits.
    task automatic request_release();
        rba_pkg::rba_req_t w;
        w.opcode       = rba_pkg::OP_RELEASE;
        w.request_size = $urandom;
        send_word(w);
    endtask

    // Hold the sender off until every expected result has come back.
    task automatic wait_all_results();
        lower_start();
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Write heap size, the unused index and alignment back to back, when idle.
    task automatic set_config(logic [31:0] heap_val, logic [4:0] align_val,
                              logic [26:0] align_pad);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_index <= rba_pkg::CFG_HEAP_BYTES;
        cfg_data  <= heap_val;
        do @(posedge clk); while (!cfg_ready);
        heap_cfg  = heap_val;
        cfg_index <= CFG_SPARE;
        cfg_data  <= $urandom;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= rba_pkg::CFG_ALIGN_LOG2;
        cfg_data  <= {align_pad, align_val};
        do @(posedge clk); while (!cfg_ready);
        align_cfg = align_val;
        cfg_valid <= 1'b0;
        config_count++;
    endtask

    // Reset settings: empty release, zero-size blocks, tail end of the heap.
    task automatic test_reset_settings();
        request_release();
        request_alloc(32'd0);
        request_alloc(32'd1);
        request_alloc(32'd0);
        request_release();
        request_release();
        request_alloc(32'd1);
        request_alloc(32'd300);
        request_alloc(32'd64768);
        request_alloc(32'd0);
        request_alloc(32'd256);
        request_alloc(32'd65537);
        request_alloc(32'hFFFF_FFFF);
        repeat (5) request_release();
    endtask

    // Alignment extremes, rounding overflow and the full-width heap.
    task automatic test_alignment();
        set_config(32'hFFFF_FFFF, 5'd0, 27'd0);
        request_alloc(32'hFFFF_FFFF);
        request_alloc(32'd1);
        request_alloc(32'd0);
        request_release();
        request_release();
        set_config(32'hFFFF_FFFF, 5'd16, 27'd0);
        request_alloc(32'hFFFF_FFFF);
        request_alloc(32'd1);
        request_alloc(32'h0001_0001);
        request_release();
        request_release();
        set_config(32'hFFFF_FFFF, 5'd31, 27'h7FF_FFFF);
        request_alloc(32'd1);
        request_alloc(32'h8000_0001);
        request_release();
        set_config(32'd1000, 5'd5, 27'd0);
        request_alloc(32'd999);
        request_alloc(32'd990);
        request_release();
    endtask

    // Placement wraps to zero once the tail is short and the front is free.
    task automatic test_wrap();
        set_config(32'd1024, 5'd8, 27'd0);
        request_alloc(32'd256);
        request_alloc(32'd200);
        request_alloc(32'd256);
        request_release();
        request_alloc(32'd512);
        request_alloc(32'd256);
        request_release();
        request_alloc(32'd256);
        request_alloc(32'd256);
        request_alloc(32'd1);
        repeat (4) request_release();
    endtask

    // A heap shrunk below the free pointer leaves only the front for wrapping.
    task automatic test_heap_shrink();
        set_config(32'd4096, 5'd8, 27'd0);
        repeat (3) request_alloc(32'd1024);
        set_config(32'd2048, 5'd8, 27'd0);
        request_alloc(32'd256);
        request_alloc(32'd4096);
        request_release();
        request_alloc(32'd512);
        repeat (3) request_release();
    endtask

    // A zero-size heap grants only zero-size blocks.
    task automatic test_zero_heap();
        set_config(32'd0, 5'd0, 27'd0);
        request_alloc(32'd0);
        request_alloc(32'd1);
        request_alloc(32'd0);
        set_config(32'd0, 5'd8, 27'd0);
        request_alloc(32'd0);
        request_alloc(32'h8000_0000);
        repeat (4) request_release();
    endtask

    // Fill the offset queue, check the full status and its precedence, drain.
    task automatic test_queue_full();
        set_config(32'd65536, 5'd0, 27'd0);
        repeat (rba_pkg::MAX_BLOCKS) request_alloc($urandom_range(0, 64));
        request_alloc(32'd1);
        request_alloc(32'd0);
        request_alloc(32'hFFFF_FFFF);
        repeat (rba_pkg::MAX_BLOCKS + 1) request_release();
    endtask

    // Random phases: each a fresh setting, a fill/drain bias and random sizes.
    task automatic test_random_traffic();
        int unsigned heap_val;
        int unsigned align_val;
        int unsigned release_pct;
        int unsigned pick;
        int unsigned size;
        rba_pkg::rba_req_t w;
        for (int phase = 0; phase < 5; phase++)
        begin
            align_val = (phase == 4) ? 16 : $urandom_range(0, 12);
            heap_val  = $urandom_range(2, 48) << align_val;
            if ($urandom_range(0, 1) == 1)
                heap_val += $urandom_range(0, (1 << align_val) - 1);
            set_config(heap_val, align_val[4:0], 27'($urandom));
            case (phase % 3)
                0: release_pct = 15;
                1: release_pct = 45;
                default: release_pct = 60;
            endcase
            no_idle = (phase == 2);
            for (int n = 0; n < 60; n++)
            begin
                if ($urandom_range(0, 49) == 0)
                    wait_all_results();
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    // Noise: any opcode with any size.
                    w.opcode       = ($urandom_range(0, 1) == 1) ?
                                     rba_pkg::OP_RELEASE : rba_pkg::OP_ALLOC;
                    w.request_size = $urandom;
                    send_word(w);
                end
                else if (pick < 6 + release_pct)
                begin
                    request_release();
                end
                else
                begin
                    case ($urandom_range(0, 5))
                        0:       size = 0;
                        1:       size = $urandom_range(0, heap_val);
                        2:       size = $urandom_range(1, 4) << align_val;
                        default: size = $urandom_range(0, heap_val / 6);
                    endcase
                    request_alloc(size);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Compare every result word with the oldest expectation.
    always @(posedge clk)
    begin
        rba_pkg::rba_rsp_t oldest_exp;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: status %0d offset %0h size %0h",
                       result.status, result.block_offset, result.block_size);
                fail_count++;
            end
            else
            begin
                oldest_exp = pending_results.pop_front();
                results_seen++;
                if (result.status !== oldest_exp.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           oldest_exp.status, result.status);
                    fail_count++;
                end
                if (result.block_offset !== oldest_exp.block_offset)
                begin
                    $error("block_offset: expected %0h, actual %0h",
                           oldest_exp.block_offset, result.block_offset);
                    fail_count++;
                end
                if (result.block_size !== oldest_exp.block_size)
                begin
                    $error("block_size: expected %0h, actual %0h",
                           oldest_exp.block_size, result.block_size);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_alignment();
        test_wrap();
        test_heap_shrink();
        test_zero_heap();
        test_queue_full();
        test_random_traffic();
        wait_all_results();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            fail_count++;
        $display("Sent %0d request words under %0d settings; %0d results checked, %0d wraps.",
                 words_sent, config_count, results_seen, wrap_count);
        $display("Status mix: ok %0d, no space %0d, too large %0d, full %0d, empty %0d.",
                 status_seen[int'(rba_pkg::ST_OK)],
                 status_seen[int'(rba_pkg::ST_NO_SPACE)],
                 status_seen[int'(rba_pkg::ST_TOO_LARGE)],
                 status_seen[int'(rba_pkg::ST_FULL)],
                 status_seen[int'(rba_pkg::ST_EMPTY)]);
        if (fail_count == 0)
            $display("ring_buffer_allocator_unit verification clean");
        else
            $display("ring_buffer_allocator_unit verification failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #3000000;
        $display("ring_buffer_allocator_unit verification failed");
        $finish;
    end

endmodule
